@@ rtl/core/twb_pkg.sv @@
// ----------------------------------------------------------------------------
// twb_pkg
// Shared types, gains and helper functions of the balance controller core.
// ----------------------------------------------------------------------------
`default_nettype none

package twb_pkg;

    // Input item: one sensor sample
    typedef struct packed {
        logic signed [10:0] gyro_rate;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic        [31:0] time_ms;
    } meas_t;

    // Result item: motor powers and fall flag
    typedef struct packed {
        logic signed [7:0] pwr_left;
        logic signed [7:0] pwr_right;
        logic              fallen;
    } motor_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_INIT_OFF = 2'd0,
        CFG_DRIVE    = 2'd1,
        CFG_STEER    = 2'd2,
        CFG_TIMEOUT  = 2'd3
    } cfg_idx_t;

    localparam int CFG_W     = 26;
    localparam int DEN_W     = 42;   // widest divisor: tick count times 1000
    localparam int DIV_STEPS = 31;   // quotient bits below the saturation point

    localparam logic [31:0]        INIT_INTERVAL_Q = 32'd918;    // 0.014 s
    localparam logic signed [31:0] TILT_INIT       = -32'sd16384; // -0.25 deg
    localparam logic [15:0]        TIMEOUT_RST     = 16'd1000;
    localparam logic [31:0]        TICK_MAX        = 32'hFFFF_FFFF;

    localparam logic signed [22:0] K_EMA    = 23'sd2147484;   // 0.0005 in Q0.32
    localparam logic signed [17:0] K_GSPEED = 18'sd75366;     // 1.15
    localparam logic signed [20:0] K_GANGLE = 21'sd491520;    // 7.5
    localparam logic signed [13:0] K_POS    = 14'sd4588;      // 0.07
    localparam logic signed [11:0] K_DRIVE  = -12'sd1311;     // -0.02
    localparam logic signed [13:0] K_WSPEED = 14'sd6554;      // 0.1

    // Datapath operations issued by the sequencer
    typedef enum logic [4:0] {
        OP_NONE,
        OP_TICK,
        OP_IV_CHK,
        OP_DIV,
        OP_IV_SET,
        OP_OFF_MUL,
        OP_OFF_ADD,
        OP_GS,
        OP_TILT_MUL,
        OP_TILT_ADD,
        OP_WHEEL,
        OP_WSUM,
        OP_WS_CHK,
        OP_WS_SET,
        OP_DRV_MUL,
        OP_POS_DRV,
        OP_ACC_GS,
        OP_ACC_TILT,
        OP_ACC_POS,
        OP_ACC_WS,
        OP_ACC_END,
        OP_POWER,
        OP_FALL_CHK,
        OP_STR_MUL,
        OP_STR_ADD,
        OP_STEER,
        OP_RESULT,
        OP_RES_FALL
    } op_t;

    typedef struct packed {
        logic load;   // latch the accepted item
        op_t  op;
    } twb_cmd_t;

    typedef struct packed {
        logic fallen;
        logic iv_sat;
        logic div_last;
        logic wsum_last;
        logic ws_skip;
        logic timed_out;
        logic first;
    } twb_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -66'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
        logic signed [47:0] r;
        if (x > 66'sd140737488355327)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (x < -66'sd140737488355328)
            r = 48'sh8000_0000_0000;
        else
            r = x[47:0];
        return r;
    endfunction

    function automatic logic signed [7:0] sat_pwr(input logic signed [33:0] x);
        logic signed [7:0] r;
        if (x > 34'sd100)
            r = 8'sd100;
        else if (x < -34'sd100)
            r = -8'sd100;
        else
            r = x[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/twb_chan_if.sv @@
// ----------------------------------------------------------------------------
// twb_chan_if
// Valid/ready channel carrying one item of a packed payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface twb_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/two_wheel_balance_controller_core.sv @@
// ----------------------------------------------------------------------------
// two_wheel_balance_controller_core
// Balance controller for a two-wheeled inverted pendulum, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                         handshake
//  -------   ---   ---------------------------------------------   ---------
//  meas      in    gyro_rate, left_count, right_count, time_ms      valid/ready
//  motor     out   pwr_left, pwr_right, fallen                      valid/ready
//  cfg       in    cfg_index, cfg_data                              cfg_we only
//
//  One item at a time. The next item can be taken in the same cycle as the
//  result shows; the two 31-step divisions of the shared restoring divider
//  (loop interval, wheel speed) take most of an item's time. The first tick
//  or a saturating interval skips the interval division, a saturating or
//  zero wheel speed skips the second, and once fallen an item goes from the
//  check state straight to the fall result.
//  Reset initialises all loop state at once; no clearing pass is needed.
//  The result waits in an output register, so a stalled sink only holds the
//  next item's final write; meas.ready is high while the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wheel_balance_controller_core
    import twb_pkg::*;
#(
    parameter int SPEED_WINDOW = 4   // wheel speed window in ticks, 1..16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    twb_chan_if.sink              meas,
    twb_chan_if.source            motor,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    twb_cmd_t  cmd;
    twb_stat_t stat;
    motor_t    result;
    logic      meas_ready;
    logic      motor_valid;

    // sequencer: decides which datapath step runs each cycle
    twb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .meas_valid  (meas.valid),
        .motor_ready (motor.ready),
        .stat        (stat),
        .cmd         (cmd),
        .meas_ready  (meas_ready),
        .motor_valid (motor_valid)
    );

    // datapath: holds loop state and configuration, computes the step
    twb_dp #(
        .SPEED_WINDOW (SPEED_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas.data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    assign meas.ready  = meas_ready;
    assign motor.valid = motor_valid;
    assign motor.data  = result;

endmodule

`default_nettype wire

@@ rtl/core/twb_ctrl.sv @@
// ----------------------------------------------------------------------------
// twb_ctrl
// Sequencer: walks the datapath through the steps of one control tick.
// ----------------------------------------------------------------------------
`default_nettype none

module twb_ctrl
    import twb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      meas_valid,
    input  wire logic      motor_ready,
    input  wire twb_stat_t stat,
    output twb_cmd_t       cmd,
    output logic           meas_ready,
    output logic           motor_valid
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TICK,
        ST_IV_CHK,
        ST_IV_DIV,
        ST_IV_SET,
        ST_OFF_MUL,
        ST_OFF_ADD,
        ST_GS,
        ST_TILT_MUL,
        ST_TILT_ADD,
        ST_WHEEL,
        ST_WSUM,
        ST_WS_CHK,
        ST_WS_DIV,
        ST_WS_SET,
        ST_DRV_MUL,
        ST_POS_DRV,
        ST_ACC_GS,
        ST_ACC_TILT,
        ST_ACC_POS,
        ST_ACC_WS,
        ST_ACC_END,
        ST_POWER,
        ST_FALL_CHK,
        ST_STR_MUL,
        ST_STR_ADD,
        ST_STEER,
        ST_RESULT,
        ST_RES_FALL
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free    = !out_valid_reg || motor_ready;
    assign meas_ready  = (state_reg == ST_IDLE);
    assign motor_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = meas_valid;
                if (meas_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:    state_next = stat.fallen ? ST_RES_FALL : ST_TICK;
            ST_TICK:
            begin
                cmd.op     = OP_TICK;
                state_next = stat.first ? ST_OFF_MUL : ST_IV_CHK;
            end
            ST_IV_CHK:
            begin
                cmd.op     = OP_IV_CHK;
                state_next = stat.iv_sat ? ST_OFF_MUL : ST_IV_DIV;
            end
            ST_IV_DIV:
            begin
                cmd.op = OP_DIV;
                if (stat.div_last)
                    state_next = ST_IV_SET;
            end
            ST_IV_SET:
            begin
                cmd.op     = OP_IV_SET;
                state_next = ST_OFF_MUL;
            end
            ST_OFF_MUL:
            begin
                cmd.op     = OP_OFF_MUL;
                state_next = ST_OFF_ADD;
            end
            ST_OFF_ADD:
            begin
                cmd.op     = OP_OFF_ADD;
                state_next = ST_GS;
            end
            ST_GS:
            begin
                cmd.op     = OP_GS;
                state_next = ST_TILT_MUL;
            end
            ST_TILT_MUL:
            begin
                cmd.op     = OP_TILT_MUL;
                state_next = ST_TILT_ADD;
            end
            ST_TILT_ADD:
            begin
                cmd.op     = OP_TILT_ADD;
                state_next = ST_WHEEL;
            end
            ST_WHEEL:
            begin
                cmd.op     = OP_WHEEL;
                state_next = ST_WSUM;
            end
            ST_WSUM:
            begin
                cmd.op = OP_WSUM;
                if (stat.wsum_last)
                    state_next = ST_WS_CHK;
            end
            ST_WS_CHK:
            begin
                cmd.op     = OP_WS_CHK;
                state_next = stat.ws_skip ? ST_DRV_MUL : ST_WS_DIV;
            end
            ST_WS_DIV:
            begin
                cmd.op = OP_DIV;
                if (stat.div_last)
                    state_next = ST_WS_SET;
            end
            ST_WS_SET:
            begin
                cmd.op     = OP_WS_SET;
                state_next = ST_DRV_MUL;
            end
            ST_DRV_MUL:
            begin
                cmd.op     = OP_DRV_MUL;
                state_next = ST_POS_DRV;
            end
            ST_POS_DRV:
            begin
                cmd.op     = OP_POS_DRV;
                state_next = ST_ACC_GS;
            end
            ST_ACC_GS:
            begin
                cmd.op     = OP_ACC_GS;
                state_next = ST_ACC_TILT;
            end
            ST_ACC_TILT:
            begin
                cmd.op     = OP_ACC_TILT;
                state_next = ST_ACC_POS;
            end
            ST_ACC_POS:
            begin
                cmd.op     = OP_ACC_POS;
                state_next = ST_ACC_WS;
            end
            ST_ACC_WS:
            begin
                cmd.op     = OP_ACC_WS;
                state_next = ST_ACC_END;
            end
            ST_ACC_END:
            begin
                cmd.op     = OP_ACC_END;
                state_next = ST_POWER;
            end
            ST_POWER:
            begin
                cmd.op     = OP_POWER;
                state_next = ST_FALL_CHK;
            end
            ST_FALL_CHK:
            begin
                cmd.op     = OP_FALL_CHK;
                state_next = stat.timed_out ? ST_RES_FALL : ST_STR_MUL;
            end
            ST_STR_MUL:
            begin
                cmd.op     = OP_STR_MUL;
                state_next = ST_STR_ADD;
            end
            ST_STR_ADD:
            begin
                cmd.op     = OP_STR_ADD;
                state_next = ST_STEER;
            end
            ST_STEER:
            begin
                cmd.op     = OP_STEER;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            ST_RES_FALL:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_RES_FALL;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !motor_ready;
        if (cmd.op == OP_RESULT || cmd.op == OP_RES_FALL)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/twb_dp.sv @@
// ----------------------------------------------------------------------------
// twb_dp
// Datapath: state, configuration, products, shared divider and result.
// ----------------------------------------------------------------------------
`default_nettype none

module twb_dp
    import twb_pkg::*;
#(
    parameter int SPEED_WINDOW = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire meas_t              meas,
    input  wire twb_cmd_t           cmd,
    output twb_stat_t               stat,
    output motor_t                  result
);

    localparam int IW = (SPEED_WINDOW > 1) ? $clog2(SPEED_WINDOW) : 1;
    localparam int SW = 33 + IW;
    localparam logic [IW-1:0] IDX_FIRST = IW'(1 % SPEED_WINDOW);
    localparam logic [IW-1:0] IDX_LAST  = IW'(SPEED_WINDOW - 1);

    // configuration
    logic [CFG_W-1:0]   init_off_reg;
    logic signed [10:0] drive_reg;
    logic signed [10:0] steer_reg;
    logic [15:0]        timeout_reg;

    // loop state
    logic [31:0]        tick_reg;
    logic [31:0]        start_reg;
    logic [31:0]        iv_reg;
    logic signed [31:0] off_reg;
    logic signed [31:0] tilt_reg;
    logic signed [47:0] pos_reg;
    logic signed [32:0] prev_reg;
    logic signed [32:0] win_reg [SPEED_WINDOW];
    logic [31:0]        last_ok_reg;
    logic signed [31:0] dt_reg;
    logic               fall_reg;
    logic [IW-1:0]      idx_reg;
    logic [4:0]         dcnt_reg;
    logic [IW-1:0]      wcnt_reg;

    // working registers
    meas_t              m_reg;
    logic               first_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [30:0]        feed_reg;
    logic [30:0]        quo_reg;
    logic signed [65:0] p_reg;
    logic signed [63:0] acc_reg;
    logic signed [32:0] gs_reg;
    logic signed [32:0] diff_reg;
    logic signed [SW-1:0] wsum_reg;
    logic               neg_reg;
    logic signed [31:0] ws_reg;
    logic signed [31:0] power_reg;
    logic signed [32:0] ps_reg;
    motor_t             out_reg;

    // combinational helpers
    logic signed [32:0] g_q, off_err, sum_c, delta_c, prev_eff;
    logic signed [47:0] pos_eff;
    logic [31:0]        el, tick_n;
    logic               iv_sat;
    logic [DEN_W:0]     div_t, div_sub;
    logic               div_ge;
    logic [IW-1:0]      idx_n;
    logic [SW-1:0]      ws_mag;
    logic [DEN_W-1:0]   ws_num, ws_den;
    logic               ws_zero, ws_big;
    logic [63:0]        acc_neg;
    logic signed [31:0] power_c;
    logic               pwr_ok, timed_out;
    logic signed [49:0] sx, sx_neg;
    logic signed [32:0] ps_c;
    logic signed [31:0] iv_s;

    logic signed [55:0] prod_off;
    logic signed [64:0] prod_tilt;
    logic signed [42:0] prod_drv, prod_str;
    logic signed [50:0] prod_kg;
    logic signed [52:0] prod_ka;
    logic signed [61:0] prod_kp;
    logic signed [45:0] prod_kw;
    logic signed [22:0] prod_kd;

    assign iv_s      = $signed({1'b0, iv_reg[30:0]});
    assign prod_off  = off_err * K_EMA;
    assign prod_tilt = gs_reg * iv_s;
    assign prod_drv  = drive_reg * iv_s;
    assign prod_str  = steer_reg * iv_s;
    assign prod_kg   = gs_reg * K_GSPEED;
    assign prod_ka   = tilt_reg * K_GANGLE;
    assign prod_kp   = pos_reg * K_POS;
    assign prod_kw   = ws_reg * K_WSPEED;
    assign prod_kd   = drive_reg * K_DRIVE;

    always_comb
    begin
        g_q      = {{6{m_reg.gyro_rate[10]}}, m_reg.gyro_rate, 16'b0};
        off_err  = g_q - {off_reg[31], off_reg};
        el       = m_reg.time_ms - start_reg;
        iv_sat   = {25'b0, el} >= {den_reg, 15'b0};
        tick_n   = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 32'd1;
        if (tick_reg == TICK_MAX)
            idx_n = idx_reg;
        else if (idx_reg == IDX_LAST)
            idx_n = '0;
        else
            idx_n = idx_reg + IW'(1);

        div_t   = {rem_reg, feed_reg[30]};
        div_sub = div_t - {1'b0, den_reg};
        div_ge  = div_t >= {1'b0, den_reg};

        prev_eff = first_reg ? 33'sd0 : prev_reg;
        pos_eff  = first_reg ? 48'sd0 : pos_reg;
        sum_c    = 33'(m_reg.left_count) + 33'(m_reg.right_count);
        delta_c  = sum_c - prev_eff;

        ws_mag  = wsum_reg[SW-1] ? SW'(-wsum_reg) : SW'(wsum_reg);
        ws_num  = DEN_W'({ws_mag, 1'b0});
        ws_den  = DEN_W'(iv_reg[30:0]) * DEN_W'(SPEED_WINDOW);
        ws_zero = (ws_mag == '0);
        ws_big  = ws_num >= ws_den;

        acc_neg = 64'(-acc_reg);
        power_c = acc_reg[63] ? (32'sd0 - $signed(acc_neg[63:32])) : acc_reg[63:32];
        pwr_ok  = (power_reg > -32'sd100) && (power_reg < 32'sd100);
        timed_out = !pwr_ok && ((m_reg.time_ms - last_ok_reg) >= {16'b0, timeout_reg});

        sx     = 50'(dt_reg) - (50'(diff_reg) <<< 16);
        sx_neg = -sx;
        ps_c   = sx[49] ? $signed({1'b0, sx_neg[49:18]})
                        : (33'sd0 - $signed({1'b0, sx[49:18]}));
    end

    always_comb
    begin
        stat.fallen    = fall_reg;
        stat.iv_sat    = iv_sat;
        stat.div_last  = (dcnt_reg == 5'(DIV_STEPS - 1));
        stat.wsum_last = (wcnt_reg == IDX_LAST);
        stat.ws_skip   = ws_zero || ws_big;
        stat.timed_out = timed_out;
        stat.first     = first_reg;
    end

    assign result = out_reg;

    // configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_off_reg <= '0;
            drive_reg    <= '0;
            steer_reg    <= '0;
            timeout_reg  <= TIMEOUT_RST;
            tick_reg     <= '0;
            start_reg    <= '0;
            iv_reg       <= '0;
            off_reg      <= '0;
            tilt_reg     <= TILT_INIT;
            pos_reg      <= '0;
            prev_reg     <= '0;
            for (int k = 0; k < SPEED_WINDOW; k++)
                win_reg[k] <= '0;
            last_ok_reg  <= '0;
            dt_reg       <= '0;
            fall_reg     <= 1'b0;
            idx_reg      <= '0;
            dcnt_reg     <= '0;
            wcnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_INIT_OFF: init_off_reg <= cfg_data;
                    CFG_DRIVE:    drive_reg    <= cfg_data[10:0];
                    CFG_STEER:    steer_reg    <= cfg_data[10:0];
                    CFG_TIMEOUT:  timeout_reg  <= cfg_data[15:0];
                    default:      init_off_reg <= init_off_reg;
                endcase
            end
            case (cmd.op)
                OP_TICK:
                begin
                    if (first_reg)
                    begin
                        tick_reg  <= 32'd1;
                        iv_reg    <= INIT_INTERVAL_Q;
                        start_reg <= m_reg.time_ms;
                        off_reg   <= 32'(signed'(init_off_reg));
                        idx_reg   <= IDX_FIRST;
                    end
                    else
                    begin
                        tick_reg <= tick_n;
                        idx_reg  <= idx_n;
                    end
                end
                OP_IV_CHK:
                begin
                    dcnt_reg <= '0;
                    if (iv_sat)
                        iv_reg <= 32'h7FFF_FFFF;
                end
                OP_DIV:      dcnt_reg <= dcnt_reg + 5'd1;
                OP_IV_SET:   iv_reg   <= {1'b0, quo_reg};
                OP_OFF_ADD:  off_reg  <= sat32(66'(off_reg) +
                                               ((p_reg + (66'sd1 <<< 31)) >>> 32));
                OP_TILT_ADD: tilt_reg <= sat32(66'(tilt_reg) +
                                               ((p_reg + 66'sd32768) >>> 16));
                OP_WHEEL:
                begin
                    prev_reg <= sum_c;
                    pos_reg  <= sat48(66'(pos_eff) + (66'(delta_c) <<< 16));
                    for (int k = 0; k < SPEED_WINDOW; k++)
                    begin
                        if (IW'(k) == idx_reg)
                            win_reg[k] <= delta_c;
                        else if (first_reg)
                            win_reg[k] <= '0;
                    end
                    if (first_reg)
                        last_ok_reg <= m_reg.time_ms;
                    wcnt_reg <= '0;
                end
                OP_WSUM:     wcnt_reg <= wcnt_reg + IW'(1);
                OP_WS_CHK:   dcnt_reg <= '0;
                OP_POS_DRV:  pos_reg  <= sat48(66'(pos_reg) - p_reg);
                OP_FALL_CHK:
                begin
                    if (pwr_ok)
                        last_ok_reg <= m_reg.time_ms;
                    else if (timed_out)
                        fall_reg <= 1'b1;
                end
                OP_STR_ADD:  dt_reg <= sat32(66'(dt_reg) + p_reg);
                default:     dt_reg <= dt_reg;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg     <= meas;
            first_reg <= (tick_reg == '0);
        end
        case (cmd.op)
            OP_TICK:     den_reg <= DEN_W'(tick_n) * DEN_W'(1000);
            OP_IV_CHK:
            begin
                rem_reg  <= DEN_W'(el[31:15]);
                feed_reg <= {el[14:0], 16'b0};
            end
            OP_DIV:
            begin
                rem_reg  <= div_ge ? div_sub[DEN_W-1:0] : div_t[DEN_W-1:0];
                quo_reg  <= {quo_reg[29:0], div_ge};
                feed_reg <= {feed_reg[29:0], 1'b0};
            end
            OP_OFF_MUL:  p_reg  <= 66'(prod_off);
            OP_GS:       gs_reg <= g_q - {off_reg[31], off_reg};
            OP_TILT_MUL: p_reg  <= 66'(prod_tilt);
            OP_WHEEL:
            begin
                diff_reg <= 33'(m_reg.right_count) - 33'(m_reg.left_count);
                wsum_reg <= '0;
            end
            OP_WSUM:     wsum_reg <= wsum_reg + SW'(win_reg[wcnt_reg]);
            OP_WS_CHK:
            begin
                neg_reg  <= wsum_reg[SW-1];
                den_reg  <= ws_den;
                rem_reg  <= ws_num;
                feed_reg <= '0;
                if (ws_zero)
                    ws_reg <= '0;
                else if (ws_big)
                    ws_reg <= wsum_reg[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            OP_WS_SET:   ws_reg <= neg_reg ? (32'sd0 - $signed({1'b0, quo_reg}))
                                           : $signed({1'b0, quo_reg});
            OP_DRV_MUL:  p_reg  <= 66'(prod_drv);
            OP_ACC_GS:
            begin
                p_reg   <= 66'(prod_kg);
                acc_reg <= 64'(prod_kd) <<< 16;
            end
            OP_ACC_TILT:
            begin
                p_reg   <= 66'(prod_ka);
                acc_reg <= acc_reg + p_reg[63:0];
            end
            OP_ACC_POS:
            begin
                p_reg   <= 66'(prod_kp);
                acc_reg <= acc_reg + p_reg[63:0];
            end
            OP_ACC_WS:
            begin
                p_reg   <= 66'(prod_kw);
                acc_reg <= acc_reg + p_reg[63:0];
            end
            OP_ACC_END:  acc_reg   <= acc_reg + p_reg[63:0];
            OP_POWER:    power_reg <= power_c;
            OP_STR_MUL:  p_reg     <= 66'(prod_str);
            OP_STEER:    ps_reg    <= ps_c;
            OP_RESULT:
            begin
                out_reg.pwr_left  <= sat_pwr(34'(power_reg) + 34'(ps_reg));
                out_reg.pwr_right <= sat_pwr(34'(power_reg) - 34'(ps_reg));
                out_reg.fallen    <= 1'b0;
            end
            OP_RES_FALL:
            begin
                out_reg.pwr_left  <= '0;
                out_reg.pwr_right <= '0;
                out_reg.fallen    <= 1'b1;
            end
            default:     acc_reg <= acc_reg;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/twb_chk.sv @@
// ----------------------------------------------------------------------------
// twb_chk
// Port-level checks of the balance controller core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module twb_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              meas_valid,
    input wire logic              meas_ready,
    input wire logic              motor_valid,
    input wire logic              motor_ready,
    input wire logic signed [7:0] pwr_left,
    input wire logic signed [7:0] pwr_right,
    input wire logic              fallen
);

    logic [1:0] pending_reg;
    logic       seen_fall_reg;
    logic       in_acc, out_acc;

    assign in_acc  = meas_valid && meas_ready;
    assign out_acc = motor_valid && motor_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            seen_fall_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc && fallen)
                seen_fall_reg <= 1'b1;
        end
    end

    // no result without an item waiting for it
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid |-> pending_reg != 2'd0)
        else $error("result shown with no item outstanding");

    // once a fall has been reported, every later result reports it
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_fall_reg |-> fallen)
        else $error("fall flag dropped");

    // fallen forces zero power
    a_fall_zero: assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid && fallen |-> pwr_left == 8'sd0 && pwr_right == 8'sd0)
        else $error("power while fallen");

    // powers stay clamped
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid |-> pwr_left >= -8'sd100 && pwr_left <= 8'sd100 &&
                        pwr_right >= -8'sd100 && pwr_right <= 8'sd100)
        else $error("power out of range");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid && !motor_ready |=> motor_valid && $stable(pwr_left) &&
                                       $stable(pwr_right) && $stable(fallen))
        else $error("stalled result changed");

endmodule

bind two_wheel_balance_controller_core twb_chk u_twb_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .meas_valid  (meas.valid),
    .meas_ready  (meas.ready),
    .motor_valid (motor.valid),
    .motor_ready (motor.ready),
    .pwr_left    (motor.data.pwr_left),
    .pwr_right   (motor.data.pwr_right),
    .fallen      (motor.data.fallen)
);

`default_nettype wire
